FILE: sv/ddkw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddkw_pkg;

	// internal fixed point: Q.30 ratios and kernel values
	localparam int FB          = 30;
	localparam int WEIGHT_BITS = 16;
	localparam int DIV_STEPS   = 32;
	localparam int SQRT_STEPS  = 31;
	// lane: offset, divider setup, divider, ratio, square, radicand, root, numerator, /3
	localparam int LANE_LAT    = 2 + DIV_STEPS + 3 + SQRT_STEPS + 2;
	localparam int MERGE_LAT   = 2;
	localparam int PIPE_LAT    = LANE_LAT + MERGE_LAT;

	localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
	localparam logic [31:0] HALF_Q30       = 32'h2000_0000;
	localparam logic [31:0] THREE_HALF_Q30 = 32'h6000_0000;
	localparam logic [31:0] R_SAT          = 32'h8000_0000;
	localparam logic [32:0] FIVE_Q30       = 33'h1_4000_0000;
	// floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
	localparam logic [31:0] RECIP3         = 32'hAAAA_AAAB;

	typedef enum logic [0:0] {
		REG_AXIS_MASK   = 1'b0,
		REG_MIN_SPACING = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic signed [31:0] centre_z;
		logic        [31:0] spacing;
	} in_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic                   out_of_support;
	} out_t;

	typedef struct packed {
		logic [30:0] phi;
		logic        outside;
	} lane_res_t;

endpackage
`default_nettype wire

FILE: sv/ddkw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage. Dividend is {rem_in, lo_in, 30'b0};
// rem_in must be below h_in.
module ddkw_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] rem_in,
	input  wire logic [1:0]  lo_in,
	input  wire logic [31:0] h_in,
	input  wire logic        ovf_in,
	output logic      [31:0] q,
	output logic             ovf
);

	logic [31:0] rem_s [0:ddkw_pkg::DIV_STEPS];
	logic [31:0] q_s   [0:ddkw_pkg::DIV_STEPS];
	logic [1:0]  lo_s  [0:ddkw_pkg::DIV_STEPS];
	logic [31:0] h_s   [0:ddkw_pkg::DIV_STEPS];
	logic        ovf_s [0:ddkw_pkg::DIV_STEPS];

	assign rem_s[0] = rem_in;
	assign q_s[0]   = '0;
	assign lo_s[0]  = lo_in;
	assign h_s[0]   = h_in;
	assign ovf_s[0] = ovf_in;

	for (genvar k = 0; k < ddkw_pkg::DIV_STEPS; k++) begin : g_step
		logic        nb;
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;

		assign nb   = (k == 0) ? lo_s[k][1] : ((k == 1) ? lo_s[k][0] : 1'b0);
		assign t    = {rem_s[k], nb};
		assign diff = t - {1'b0, h_s[k]};
		assign ge   = (t >= {1'b0, h_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[31:0] : t[31:0];
				q_s[k+1]   <= {q_s[k][30:0], ge};
				lo_s[k+1]  <= lo_s[k];
				h_s[k+1]   <= h_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign q   = q_s[ddkw_pkg::DIV_STEPS];
	assign ovf = ovf_s[ddkw_pkg::DIV_STEPS];

endmodule
`default_nettype wire

FILE: sv/ddkw_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage, floor result.
module ddkw_sqrt #(
	parameter int SB = 34
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [61:0]   radicand,
	input  wire logic [SB-1:0] side_in,
	output logic      [30:0]   root,
	output logic      [SB-1:0] side_out
);

	logic [61:0]   s_s    [0:ddkw_pkg::SQRT_STEPS];
	logic [31:0]   rem_s  [0:ddkw_pkg::SQRT_STEPS];
	logic [30:0]   root_s [0:ddkw_pkg::SQRT_STEPS];
	logic [SB-1:0] side_s [0:ddkw_pkg::SQRT_STEPS];

	assign s_s[0]    = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < ddkw_pkg::SQRT_STEPS; k++) begin : g_step
		logic [33:0] t;
		logic [33:0] trial;
		logic [33:0] diff;
		logic        ge;

		assign t     = {rem_s[k], s_s[k][61-2*k -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign diff  = t - trial;
		assign ge    = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				s_s[k+1]    <= s_s[k];
				rem_s[k+1]  <= ge ? diff[31:0] : t[31:0];
				root_s[k+1] <= {root_s[k][29:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign root     = root_s[ddkw_pkg::SQRT_STEPS];
	assign side_out = side_s[ddkw_pkg::SQRT_STEPS];

endmodule
`default_nettype wire

FILE: sv/ddkw_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis: offset -> ratio r -> 1D kernel value phi(r) in Q.30.
module ddkw_lane (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] point,
	input  wire logic signed [31:0] centre,
	input  wire logic        [31:0] spacing,
	input  wire logic               axis_on,
	output ddkw_pkg::lane_res_t     res
);

	logic signed [32:0] d;
	logic        [32:0] mag;
	logic        [32:0] mag_s1;
	logic        [31:0] h_s1;
	logic        [31:0] rem_s2;
	logic        [1:0]  lo_s2;
	logic        [31:0] h_s2;
	logic               ovf_s2;
	logic        [31:0] q;
	logic               ovf;

	assign d   = $signed({centre[31], centre}) - $signed({point[31], point});
	assign mag = d[32] ? 33'(-d) : 33'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= axis_on ? mag : '0;
			h_s1   <= spacing;
			rem_s2 <= {1'b0, mag_s1[32:2]};
			lo_s2  <= mag_s1[1:0];
			h_s2   <= h_s1;
			// quotient would not fit 32 bits
			ovf_s2 <= ({1'b0, mag_s1} >= {h_s1, 2'b00});
		end
	end

	ddkw_div u_div (
		.clk    (clk),
		.en     (en),
		.rem_in (rem_s2),
		.lo_in  (lo_s2),
		.h_in   (h_s2),
		.ovf_in (ovf_s2),
		.q      (q),
		.ovf    (ovf)
	);

	logic [31:0] r;
	logic [31:0] u_full;
	logic [31:0] r_s3;
	logic [29:0] u_s3;
	logic        inner_s3;
	logic        outside_s3;
	logic [59:0] sq_s4;
	logic [31:0] r_s4;
	logic        inner_s4;
	logic        outside_s4;
	logic [61:0] rad_s5;
	logic [33:0] side_s5;

	assign r      = (ovf || (q > ddkw_pkg::R_SAT)) ? ddkw_pkg::R_SAT : q;
	assign u_full = (r <= ddkw_pkg::HALF_Q30) ? r :
		((r > ddkw_pkg::ONE_Q30) ? (r - ddkw_pkg::ONE_Q30) : (ddkw_pkg::ONE_Q30 - r));

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3       <= r;
			u_s3       <= u_full[29:0];
			inner_s3   <= (r <= ddkw_pkg::HALF_Q30);
			outside_s3 <= (r > ddkw_pkg::THREE_HALF_Q30);
			sq_s4      <= u_s3 * u_s3;
			r_s4       <= r_s3;
			inner_s4   <= inner_s3;
			outside_s4 <= outside_s3;
			// 1.0 - 3 u^2 in Q.60; wraps only for lanes already outside
			rad_s5     <= {2'b01, 60'b0} - ({2'b00, sq_s4} + {1'b0, sq_s4, 1'b0});
			side_s5    <= {r_s4, inner_s4, outside_s4};
		end
	end

	logic [30:0] root;
	logic [33:0] side_q;
	logic [31:0] r_sq;
	logic        inner_sq;
	logic        outside_sq;

	ddkw_sqrt #(.SB(34)) u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s5),
		.side_in  (side_s5),
		.root     (root),
		.side_out (side_q)
	);

	assign r_sq       = side_q[33:2];
	assign inner_sq   = side_q[1];
	assign outside_sq = side_q[0];

	logic [33:0] sub;
	logic [33:0] top_diff;
	logic [31:0] numer;
	logic [31:0] numer_s6;
	logic        outside_s6;
	logic [63:0] prod;
	logic [30:0] phi_s7;
	logic        outside_s7;

	assign sub      = {2'b00, r_sq} + {1'b0, r_sq, 1'b0} + {3'b000, root};
	assign top_diff = {1'b0, ddkw_pkg::FIVE_Q30} - sub;
	always_comb begin
		if (inner_sq) begin
			numer = ddkw_pkg::ONE_Q30 + {1'b0, root};
		end else if (sub >= {1'b0, ddkw_pkg::FIVE_Q30}) begin
			numer = '0;
		end else begin
			// /6 taken as /2 then /3
			numer = top_diff[32:1];
		end
	end

	assign prod = numer_s6 * ddkw_pkg::RECIP3;

	always_ff @(posedge clk) begin
		if (en) begin
			numer_s6   <= numer;
			outside_s6 <= outside_sq;
			phi_s7     <= prod[63:33];
			outside_s7 <= outside_s6;
		end
	end

	assign res.phi     = phi_s7;
	assign res.outside = outside_s7;

endmodule
`default_nettype wire

FILE: sv/ddkw_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Axis product, truncated after each multiply; zero if out of support.
module ddkw_merge (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire ddkw_pkg::lane_res_t lane_x,
	input  wire ddkw_pkg::lane_res_t lane_y,
	input  wire ddkw_pkg::lane_res_t lane_z,
	input  wire logic                spacing_bad,
	output ddkw_pkg::out_t           res
);

	logic [61:0] p1;
	logic [30:0] w_s1;
	logic [30:0] phi_z_s1;
	logic        zero_s1;
	logic [61:0] p2;
	logic [30:0] w_s2;
	logic        zero_s2;

	assign p1 = lane_x.phi * lane_y.phi;
	assign p2 = w_s1 * phi_z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1     <= p1[60:30];
			phi_z_s1 <= lane_z.phi;
			zero_s1  <= spacing_bad || lane_x.outside || lane_y.outside || lane_z.outside;
			w_s2     <= p2[60:30];
			zero_s2  <= zero_s1;
		end
	end

	assign res.weight         = zero_s2 ? '0 :
		w_s2[ddkw_pkg::FB-1 -: ddkw_pkg::WEIGHT_BITS];
	assign res.out_of_support = zero_s2;

endmodule
`default_nettype wire

FILE: sv/discrete_delta_kernel_weight.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// in       | in_valid / in_stall        | in_data  (ddkw_pkg::in_t)
// out      | out_valid / out_stall      | out_data (ddkw_pkg::out_t)
// cfg      | cfg_valid / cfg_ready (=1) | cfg_index, cfg_data
//
// One item per cycle unless the output stalls; depth is set by the 32-step
// divider and 31-step square root pipelines in each of the three axis lanes.
// Reset restores axis_mask = 7 and min_spacing = 1 and empties the pipeline.
// All stages move together; they halt only while the last stage holds a result
// and the output register is full and stalled.
module discrete_delta_kernel_weight (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ddkw_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ddkw_pkg::out_t     out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [0:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	logic [2:0]  axis_mask_q;
	logic [31:0] min_spacing_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_mask_q   <= 3'd7;
			min_spacing_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ddkw_pkg::cfg_idx_t'(cfg_index))
				ddkw_pkg::REG_AXIS_MASK:   axis_mask_q   <= cfg_data[2:0];
				ddkw_pkg::REG_MIN_SPACING: min_spacing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_q   [1:ddkw_pkg::PIPE_LAT];
	logic bad_q [1:ddkw_pkg::LANE_LAT];
	logic out_valid_q;
	ddkw_pkg::out_t out_q;

	assign en       = !v_q[ddkw_pkg::PIPE_LAT] || !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ddkw_pkg::PIPE_LAT; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_q[1] <= in_valid;
			for (int i = 2; i <= ddkw_pkg::PIPE_LAT; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_q[1] <= (in_data.spacing == '0) || (in_data.spacing < min_spacing_q);
			for (int i = 2; i <= ddkw_pkg::LANE_LAT; i++) begin
				bad_q[i] <= bad_q[i-1];
			end
		end
	end

	ddkw_pkg::lane_res_t lane_x;
	ddkw_pkg::lane_res_t lane_y;
	ddkw_pkg::lane_res_t lane_z;
	ddkw_pkg::out_t      merged;

	ddkw_lane u_lane_x (
		.clk (clk), .en (en), .point (in_data.point_x), .centre (in_data.centre_x),
		.spacing (in_data.spacing), .axis_on (axis_mask_q[0]), .res (lane_x)
	);
	ddkw_lane u_lane_y (
		.clk (clk), .en (en), .point (in_data.point_y), .centre (in_data.centre_y),
		.spacing (in_data.spacing), .axis_on (axis_mask_q[1]), .res (lane_y)
	);
	ddkw_lane u_lane_z (
		.clk (clk), .en (en), .point (in_data.point_z), .centre (in_data.centre_z),
		.spacing (in_data.spacing), .axis_on (axis_mask_q[2]), .res (lane_z)
	);

	ddkw_merge u_merge (
		.clk         (clk),
		.en          (en),
		.lane_x      (lane_x),
		.lane_y      (lane_y),
		.lane_z      (lane_z),
		.spacing_bad (bad_q[ddkw_pkg::LANE_LAT]),
		.res         (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_q[ddkw_pkg::PIPE_LAT]) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_q[ddkw_pkg::PIPE_LAT]) begin
			out_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_q[ddkw_pkg::PIPE_LAT] && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_q[ddkw_pkg::PIPE_LAT]) |=> out_valid_q)
		else $error("finished transfer did not reach output register");

	a_hold_line: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_q[1] == $past(v_q[1])) &&
			(v_q[ddkw_pkg::PIPE_LAT] == $past(v_q[ddkw_pkg::PIPE_LAT])))
		else $error("pipeline moved while halted");

	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.out_of_support) |-> (out_data.weight == '0))
		else $error("nonzero weight outside support");

endmodule
`default_nettype wire

FILE: bench/discrete_delta_kernel_weight_tb.sv
`timescale 1ns / 1ps
module discrete_delta_kernel_weight_tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ddkw_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	ddkw_pkg::out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	discrete_delta_kernel_weight DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the configuration registers
	logic [2:0] mask_shadow;
	logic [31:0] min_spacing_shadow;

	ddkw_pkg::out_t weight_q[$];
	int errors;
	int n_sent;
	int n_checked;
	int n_outside;
	int hold_cycles;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("discrete_delta_kernel_weight verification failed");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// one-axis kernel value in Q.30, ratio in Q.30 (at most 1.5)
	function automatic logic [63:0] kernel_1d(logic [63:0] r);
		logic [63:0] one;
		logic [63:0] t;
		logic [63:0] sq;
		logic [63:0] sub;
		logic [63:0] top;
		one = 64'd1 << ddkw_pkg::FB;
		if (r <= (64'd1 << (ddkw_pkg::FB - 1))) begin
			sq = int_sqrt((64'd1 << (2 * ddkw_pkg::FB)) - 3 * (r * r));
			return (one + sq) / 3;
		end
		t = (r > one) ? r - one : one - r;
		sq = int_sqrt((64'd1 << (2 * ddkw_pkg::FB)) - 3 * (t * t));
		sub = 3 * r + sq;
		top = 5 * one;
		if (sub >= top)
			return 0;
		return (top - sub) / 6;
	endfunction

	function automatic ddkw_pkg::out_t predict_weight(ddkw_pkg::in_t it);
		ddkw_pkg::out_t res;
		logic [63:0] w;
		logic [63:0] h;
		logic [63:0] mag;
		logic [63:0] r;
		longint d;
		logic signed [31:0] p[3];
		logic signed [31:0] c[3];
		res.weight = '0;
		res.out_of_support = 1'b1;
		h = {32'd0, it.spacing};
		if (h == 0 || it.spacing < min_spacing_shadow)
			return res;
		p = '{it.point_x, it.point_y, it.point_z};
		c = '{it.centre_x, it.centre_y, it.centre_z};
		w = 64'd1 << ddkw_pkg::FB;
		for (int i = 0; i < 3; i++) begin
			d = longint'(c[i]) - longint'(p[i]);
			mag = (d < 0) ? -d : d;
			if (!mask_shadow[i])
				mag = 0;
			r = (mag << ddkw_pkg::FB) / h;
			if (r > (64'd2 << ddkw_pkg::FB))
				r = 64'd2 << ddkw_pkg::FB;
			if (r > (64'd3 << (ddkw_pkg::FB - 1)))
				return res;
			w = (w * kernel_1d(r)) >> ddkw_pkg::FB;
		end
		res.weight = ddkw_pkg::WEIGHT_BITS'(w >> (ddkw_pkg::FB - ddkw_pkg::WEIGHT_BITS));
		res.out_of_support = 1'b0;
		return res;
	endfunction

	task automatic send_pair(ddkw_pkg::in_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		weight_q.push_back(predict_weight(it));
		n_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (weight_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(ddkw_pkg::cfg_idx_t idx, logic [31:0] value);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == ddkw_pkg::REG_AXIS_MASK)
			mask_shadow = value[2:0];
		else
			min_spacing_shadow = value;
	endtask

	// point-cell pair at given offsets (Q16.16) from a random point
	function automatic ddkw_pkg::in_t make_pair(int dx, int dy, int dz, logic [31:0] h);
		ddkw_pkg::in_t it;
		it.point_x = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
		it.point_y = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
		it.point_z = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
		it.centre_x = it.point_x + dx;
		it.centre_y = it.point_y + dy;
		it.centre_z = it.point_z + dz;
		it.spacing = h;
		return it;
	endfunction

	function automatic ddkw_pkg::in_t random_pair();
		ddkw_pkg::in_t it;
		int h;
		if ($urandom_range(0, 9) < 7) begin
			h = $urandom_range(16, 1 << 20);
			return make_pair($urandom_range(0, 4 * h) - 2 * h,
				$urandom_range(0, 4 * h) - 2 * h,
				$urandom_range(0, 4 * h) - 2 * h, h);
		end
		it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 1))
			it.spacing = $urandom;
		return it;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ddkw_pkg::REG_AXIS_MASK;
		cfg_data = '0;
		mask_shadow = 3'd7;
		min_spacing_shadow = 32'd1;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_outside = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		test_backpressure();
		test_drain_pause();
		test_random();
		go_idle();
		fork
			wait (weight_q.size() == 0);
			begin
				repeat (100000) @(posedge clk);
				$display("discrete_delta_kernel_weight verification failed");
				$finish;
			end
		join_any
		disable fork;
		repeat (ddkw_pkg::PIPE_LAT + 10) @(posedge clk);
		$display("Sent %0d point-cell pairs, checked %0d weights (%0d out of support),",
			n_sent, n_checked, n_outside);
		$display("over several axis masks and minimum spacings incl. extremes and stalls.");
		if (errors == 0 && weight_q.size() == 0)
			$display("discrete_delta_kernel_weight verification clean");
		else
			$display("discrete_delta_kernel_weight verification failed");
		$finish;
	end

	// extremes, branch boundaries and forced-zero cases, reset config and others
	task automatic test_directed();
		ddkw_pkg::in_t it;
		int h;
		h = 32'h0001_0000;
		send_pair(make_pair(0, 0, 0, h));
		send_pair(make_pair(h / 2, -h / 2, 0, h));             // r exactly 0.5
		send_pair(make_pair(h / 2 + 1, 0, 0, h));
		send_pair(make_pair(h, -h, h, h));                     // r exactly 1.0
		send_pair(make_pair(3 * h / 2, 0, 0, h));              // r exactly 1.5
		send_pair(make_pair(0, 3 * h / 2 + 1, 0, h));          // just outside
		send_pair(make_pair(0, 0, -(3 * h / 2 + 1), h));
		send_pair(make_pair(100, 200, 300, 0));                // zero spacing
		send_pair(make_pair(5, 5, 5, 32'hffff_ffff));
		send_pair(make_pair(5, 5, 5, 1));
		it = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'd3};
		send_pair(it);                                         // saturated ratio
		it = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'hffff_ffff};
		send_pair(it);
		it = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'hffff_ffff};
		send_pair(it);
		write_reg(ddkw_pkg::REG_MIN_SPACING, 32'h0000_8000);
		send_pair(make_pair(10, 10, 10, 32'h0000_7fff));       // below minimum
		send_pair(make_pair(10, 10, 10, 32'h0000_8000));
		write_reg(ddkw_pkg::REG_MIN_SPACING, 32'd0);
		send_pair(make_pair(1, 2, 3, 0));
		send_pair(make_pair(0, 0, 0, 1));
		write_reg(ddkw_pkg::REG_AXIS_MASK, 32'd0);
		it = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'd1};
		send_pair(it);                                         // all axes masked
		write_reg(ddkw_pkg::REG_AXIS_MASK, 32'd5);
		send_pair(make_pair(h / 4, 9 * h, h / 4, h));
	endtask

	task automatic test_config_sweep();
		logic [31:0] mins[4];
		mins = '{32'd0, 32'd1, 32'hffff_ffff, 32'h0002_0000};
		for (int m = 0; m < 8; m++) begin
			write_reg(ddkw_pkg::REG_AXIS_MASK, 32'(m));
			write_reg(ddkw_pkg::REG_MIN_SPACING, mins[m % 4]);
			repeat (40) send_pair(random_pair());
		end
		write_reg(ddkw_pkg::REG_AXIS_MASK, 32'd7);
		write_reg(ddkw_pkg::REG_MIN_SPACING, 32'd1);
	endtask

	task automatic test_random();
		for (int k = 0; k < 500; k++) begin
			if (k % 100 == 0)
				no_idle = (k == 200);
			send_pair(random_pair());
		end
		no_idle = 1'b0;
	endtask

	// receiver holds off long enough for the pipeline to fill and stall input
	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (150) send_pair(random_pair());
	endtask

	task automatic test_drain_pause();
		repeat (30) send_pair(random_pair());
		go_idle();
		repeat (30) send_pair(random_pair());
	endtask

	// receiver: random stall after each accepted transfer (none while no_idle), plus long hold-offs
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (out_valid && !out_stall && !no_idle)
					stall_left = $urandom_range(0, 3);
			end
		end
	end

	always @(posedge clk) begin
		ddkw_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (weight_q.size() == 0) begin
				$error("weight transfer with nothing expected: weight %0h oos %0b",
					out_data.weight, out_data.out_of_support);
				errors++;
			end else begin
				want = weight_q.pop_front();
				n_checked++;
				if (want.out_of_support)
					n_outside++;
				if (out_data.weight !== want.weight) begin
					$error("weight: expected %0h, got %0h", want.weight, out_data.weight);
					errors++;
				end
				if (out_data.out_of_support !== want.out_of_support) begin
					$error("out_of_support: expected %0b, got %0b",
						want.out_of_support, out_data.out_of_support);
					errors++;
				end
			end
		end
	end

endmodule
